FILE: hw/rtl/line_steering_pid_top_assert.svh
// Assertion macros for the line steering PID block.
// Used by lsp_seq.sv; needs clk and rst_n in scope at each use.
`ifndef LINE_STEERING_PID_TOP_ASSERT_SVH
`define LINE_STEERING_PID_TOP_ASSERT_SVH

// same-cycle implication
`define LSP_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsp check failed");

// next-cycle implication
`define LSP_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsp next-cycle check failed");

`endif

FILE: hw/rtl/lsp_pkg.sv
// Package for the line steering PID block: config struct, microcode word,
// the microcode ROM and shared constants. No dependencies.
package lsp_pkg;

  localparam int CENTER_PIXEL = 64;

  // last seen side of the line
  localparam logic [1:0] DIR_LEFT   = 2'd0;
  localparam logic [1:0] DIR_MIDDLE = 2'd1;
  localparam logic [1:0] DIR_RIGHT  = 2'd2;
  localparam logic [1:0] DIR_UNDEF  = 2'd3;

  typedef enum logic [2:0] {
    REG_PROP_GAIN, REG_INTEG_GAIN, REG_DERIV_GAIN, REG_ACCUM_GAIN,
    REG_ACCUM_MAX, REG_ACCUM_MIN, REG_LOST_ANGLE, REG_TERM_ENABLE
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] integ_gain;
    logic signed [15:0] deriv_gain;
    logic signed [15:0] accum_gain;
    logic signed [23:0] accum_max;
    logic signed [23:0] accum_min;
    logic signed [15:0] lost_angle;
    logic [2:0]         term_enable;
  } cfg_t;

  typedef enum logic [1:0] {GSEL_P, GSEL_I, GSEL_D, GSEL_A} gain_sel_t;
  typedef enum logic [1:0] {BSEL_ERR, BSEL_INTEG, BSEL_DIFF} opb_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_ADD, ACC_ADD_SHR} acc_op_t;
  typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_START = 3'd0;
  localparam step_t STEP_LOST  = 3'd5;
  localparam step_t NUM_STEPS  = 3'd6;

  typedef struct packed {
    gain_sel_t gain_sel;
    opb_sel_t  opb_sel;
    acc_op_t   acc_op;
    term_t     gate;      // enable bit that qualifies acc add and state writes
    logic      integ_wr;
    logic      prev_wr;
    logic      jmp_lost;  // jump to jmp_tgt when the line was not found
    step_t     jmp_tgt;
    logic      last;
    logic      lost_out;
  } ctl_word_t;

  typedef struct packed {
    logic      fire;
    ctl_word_t cw;
  } seq_ctl_t;

  typedef struct packed {
    logic found;
    logic out_free;
  } dp_stat_t;

  // Microcode. The multiplier result lands in prod_r one step after issue.
  function automatic ctl_word_t ucode_rom(input step_t addr);
    ctl_word_t w;
    w = '{gain_sel: GSEL_P, opb_sel: BSEL_ERR, acc_op: ACC_HOLD, gate: TERM_P,
          integ_wr: 1'b0, prev_wr: 1'b0, jmp_lost: 1'b0, jmp_tgt: STEP_START,
          last: 1'b0, lost_out: 1'b0};
    case (addr)
      3'd0: begin
        w.gain_sel = GSEL_P;  w.opb_sel = BSEL_ERR;  w.acc_op = ACC_CLR;
        w.jmp_lost = 1'b1;    w.jmp_tgt = STEP_LOST;
      end
      3'd1: begin
        w.gain_sel = GSEL_A;  w.opb_sel = BSEL_ERR;
        w.acc_op = ACC_ADD;   w.gate = TERM_P;
      end
      3'd2: begin
        w.gain_sel = GSEL_D;  w.opb_sel = BSEL_DIFF;
        w.integ_wr = 1'b1;    w.gate = TERM_I;
      end
      3'd3: begin
        w.gain_sel = GSEL_I;  w.opb_sel = BSEL_INTEG;
        w.acc_op = ACC_ADD;   w.gate = TERM_D;  w.prev_wr = 1'b1;
      end
      3'd4: begin
        w.acc_op = ACC_ADD_SHR;  w.gate = TERM_I;  w.last = 1'b1;
      end
      3'd5: begin
        w.lost_out = 1'b1;  w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/lsp_if.sv
// Valid/ready channel interfaces for the line steering PID block.
// Depends on nothing.
interface lsp_in_if;
  logic       valid;
  logic       ready;
  logic       line_found;
  logic [6:0] line_position;
  logic [1:0] last_dir;

  modport source (output valid, line_found, line_position, last_dir, input ready);
  modport sink   (input valid, line_found, line_position, last_dir, output ready);
endinterface

interface lsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_cmd;

  modport source (output valid, steer_cmd, input ready);
  modport sink   (input valid, steer_cmd, output ready);
endinterface

FILE: hw/rtl/lsp_cfg.sv
// APB-style configuration register file for the line steering PID block.
// Depends on lsp_pkg.
module lsp_cfg
  import lsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_PROP_GAIN:   cfg_nxt.prop_gain   = pwdata[15:0];
        REG_INTEG_GAIN:  cfg_nxt.integ_gain  = pwdata[15:0];
        REG_DERIV_GAIN:  cfg_nxt.deriv_gain  = pwdata[15:0];
        REG_ACCUM_GAIN:  cfg_nxt.accum_gain  = pwdata[15:0];
        REG_ACCUM_MAX:   cfg_nxt.accum_max   = pwdata[23:0];
        REG_ACCUM_MIN:   cfg_nxt.accum_min   = pwdata[23:0];
        REG_LOST_ANGLE:  cfg_nxt.lost_angle  = pwdata[15:0];
        REG_TERM_ENABLE: cfg_nxt.term_enable = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= 16'sd256;
      cfg_r.integ_gain  <= '0;
      cfg_r.deriv_gain  <= '0;
      cfg_r.accum_gain  <= 16'sd256;
      cfg_r.accum_max   <= 24'h7F_FFFF;
      cfg_r.accum_min   <= 24'h80_0000;
      cfg_r.lost_angle  <= '0;
      cfg_r.term_enable <= 3'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_PROP_GAIN:   prdata[15:0] = cfg_r.prop_gain;
      REG_INTEG_GAIN:  prdata[15:0] = cfg_r.integ_gain;
      REG_DERIV_GAIN:  prdata[15:0] = cfg_r.deriv_gain;
      REG_ACCUM_GAIN:  prdata[15:0] = cfg_r.accum_gain;
      REG_ACCUM_MAX:   prdata[23:0] = cfg_r.accum_max;
      REG_ACCUM_MIN:   prdata[23:0] = cfg_r.accum_min;
      REG_LOST_ANGLE:  prdata[15:0] = cfg_r.lost_angle;
      REG_TERM_ENABLE: prdata[2:0]  = cfg_r.term_enable;
      default: ;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/lsp_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on lsp_pkg and line_steering_pid_top_assert.svh.
`include "line_steering_pid_top_assert.svh"

module lsp_seq
  import lsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output seq_ctl_t ctl
);

  logic      busy_r, busy_nxt;
  step_t     step_r, step_nxt;
  ctl_word_t cw;
  logic      fire;

  assign cw   = ucode_rom(step_r);
  // the final step waits while the output register holds an item that out_ready does not take
  assign fire = busy_r && (!cw.last || stat.out_free);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_START;
    end else if (fire) begin
      if (cw.last) begin
        busy_nxt = 1'b0;
        step_nxt = STEP_START;
      end else if (cw.jmp_lost && !stat.found) begin
        step_nxt = cw.jmp_tgt;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_START;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy     = busy_r;
  assign ctl.fire = fire;
  assign ctl.cw   = cw;

  `LSP_CHECK(a_idle_at_start, !busy_r, step_r == STEP_START)
  `LSP_CHECK(a_step_in_rom, busy_r, step_r < NUM_STEPS)
  `LSP_CHECK(a_no_start_busy, start, !busy_r)
  `LSP_CHECK_NEXT(a_start_runs, start, busy_r && step_r == STEP_START)

endmodule

FILE: hw/rtl/lsp_dp.sv
// Datapath: one shared 16x24 multiplier, accumulator, integrator with clamp,
// previous error and the output register. Depends on lsp_pkg.
module lsp_dp
  import lsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               in_found,
  input  logic [6:0]         in_pos,
  input  logic [1:0]         in_dir,
  input  cfg_t               cfg,
  input  seq_ctl_t           ctl,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_cmd,
  output dp_stat_t           stat
);

  logic signed [6:0]  err_r, prev_r;
  logic               found_r;
  logic [1:0]         dir_r;
  logic signed [39:0] prod_r, prod_nxt;
  logic signed [33:0] acc_r, acc_nxt, acc_sum, term_add;
  logic signed [23:0] integ_r, integ_nxt;
  logic signed [15:0] steer_r, steer_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic signed [11:0] err_wide;
  logic signed [6:0]  err_in;
  logic signed [15:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [7:0]  diff;
  logic               gate_on;
  logic signed [24:0] isum, imax, imin;
  logic signed [15:0] lost_val, acc_sat;
  ctl_word_t          cw;

  assign cw = ctl.cw;

  // error = position - center, saturated to the 7-bit range
  assign err_wide = $signed({5'b0, in_pos}) - 12'(CENTER_PIXEL);
  always_comb begin
    if (err_wide > 12'sd63)       err_in = 7'sd63;
    else if (err_wide < -12'sd64) err_in = -7'sd64;
    else                          err_in = err_wide[6:0];
  end

  assign diff = {err_r[6], err_r} - {prev_r[6], prev_r};

  always_comb begin
    case (cw.gain_sel)
      GSEL_P:  mul_a = cfg.prop_gain;
      GSEL_I:  mul_a = cfg.integ_gain;
      GSEL_D:  mul_a = cfg.deriv_gain;
      GSEL_A:  mul_a = cfg.accum_gain;
      default: mul_a = cfg.prop_gain;
    endcase
    case (cw.opb_sel)
      BSEL_ERR:   mul_b = {{17{err_r[6]}}, err_r};
      BSEL_INTEG: mul_b = integ_r;
      BSEL_DIFF:  mul_b = {{16{diff[7]}}, diff};
      default:    mul_b = integ_r;
    endcase
    case (cw.gate)
      TERM_P:  gate_on = cfg.term_enable[0];
      TERM_I:  gate_on = cfg.term_enable[1];
      TERM_D:  gate_on = cfg.term_enable[2];
      default: gate_on = 1'b0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    term_add = '0;
    case (cw.acc_op)
      ACC_ADD:     if (gate_on) term_add = prod_r[33:0];
      ACC_ADD_SHR: if (gate_on) term_add = {{2{prod_r[39]}}, prod_r[39:8]};
      default:     term_add = '0;
    endcase
  end

  assign acc_sum = acc_r + term_add;

  always_comb begin
    case (cw.acc_op)
      ACC_CLR:     acc_nxt = '0;
      ACC_ADD:     acc_nxt = acc_sum;
      ACC_ADD_SHR: acc_nxt = acc_sum;
      default:     acc_nxt = acc_r;
    endcase
  end

  // integrator: upper limit tested first
  assign isum = {integ_r[23], integ_r} + prod_r[24:0];
  assign imax = {cfg.accum_max[23], cfg.accum_max};
  assign imin = {cfg.accum_min[23], cfg.accum_min};
  always_comb begin
    if (isum > imax)      integ_nxt = cfg.accum_max;
    else if (isum < imin) integ_nxt = cfg.accum_min;
    else                  integ_nxt = isum[23:0];
  end

  always_comb begin
    case (dir_r)
      DIR_RIGHT:  lost_val = cfg.lost_angle;
      DIR_MIDDLE: lost_val = '0;
      default: lost_val = (cfg.lost_angle == 16'sh8000) ? 16'sh7FFF : -cfg.lost_angle;
    endcase
  end

  always_comb begin
    if (acc_sum > 34'sd32767)       acc_sat = 16'sh7FFF;
    else if (acc_sum < -34'sd32768) acc_sat = 16'sh8000;
    else                            acc_sat = acc_sum[15:0];
  end

  assign steer_nxt = cw.lost_out ? lost_val : acc_sat;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.fire && cw.last) out_valid_nxt = 1'b1;
    else if (out_ready)      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r   <= err_in;
      found_r <= in_found;
      dir_r   <= in_dir;
    end
    if (ctl.fire) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
      if (cw.last) steer_r <= steer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctl.fire && gate_on && cw.integ_wr) integ_r <= integ_nxt;
      if (ctl.fire && gate_on && cw.prev_wr)  prev_r  <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cmd        = steer_r;
  assign stat.found     = found_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

FILE: hw/rtl/line_steering_pid_top.sv
// Line steering PID top level. Each accepted item runs the microcode program
// around the shared multiplier (steps 0 to 4 if the line is found, 0 and 5 if
// lost); a new item is accepted only once the sequencer is idle again.
// Reset (rst_n, synchronous) clears the sequencer, output valid, integrator,
// previous error, and loads the register reset values.
// Depends on lsp_pkg, lsp_if, lsp_cfg, lsp_seq and lsp_dp.
module line_steering_pid_top
  import lsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lsp_in_if.sink      in_ch,
  lsp_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  seq_ctl_t ctl;
  dp_stat_t stat;
  logic     busy;
  logic     in_fire;

  assign pready      = 1'b1;
  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;

  lsp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lsp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  lsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_found  (in_ch.line_found),
    .in_pos    (in_ch.line_position),
    .in_dir    (in_ch.last_dir),
    .cfg       (cfg),
    .ctl       (ctl),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_cmd   (out_ch.steer_cmd),
    .stat      (stat)
  );

endmodule

FILE: sim/line_steering_pid_top_tb.sv
// Self-checking testbench for line_steering_pid_top: directed and random control
// ticks under several idle/stall patterns, checked against an in-bench PID predictor.
// Depends on lsp_pkg, lsp_if and the RTL of line_steering_pid_top.
module line_steering_pid_top_tb;
  import lsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int N_RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 141;

  typedef struct packed {
    logic       found;
    logic [6:0] pos;
    logic [1:0] dir;
  } frame_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lsp_in_if  in_ch();
  lsp_out_if out_ch();

  line_steering_pid_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's registers and controller state
  cfg_t   shadow;
  longint integ_acc;
  longint last_err;

  frame_t             frame_q[$];
  logic signed [15:0] steer_expect_q[$];
  frame_t             nxt_frame;

  int n_queued;
  int n_accepted;
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int hold_served;
  int hold_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [15:0] steer_predict(input logic found,
                                                       input logic [6:0] pos,
                                                       input logic [1:0] dir);
    longint cmd;
    longint err;
    longint s;
    longint lost;
    cmd = 0;
    if (found) begin
      err = longint'(pos) - CENTER_PIXEL;
      if (err > 63) err = 63;
      if (err < -64) err = -64;
      if (shadow.term_enable[TERM_P])
        cmd += longint'($signed(shadow.prop_gain)) * err;
      if (shadow.term_enable[TERM_I]) begin
        s = integ_acc + longint'($signed(shadow.accum_gain)) * err;
        // upper limit wins when the limits are crossed
        if (s > longint'($signed(shadow.accum_max))) s = longint'($signed(shadow.accum_max));
        else if (s < longint'($signed(shadow.accum_min)))
          s = longint'($signed(shadow.accum_min));
        integ_acc = s;
        cmd += (longint'($signed(shadow.integ_gain)) * integ_acc) >>> 8;
      end
      if (shadow.term_enable[TERM_D]) begin
        cmd += longint'($signed(shadow.deriv_gain)) * (err - last_err);
        last_err = err;
      end
    end else begin
      lost = longint'($signed(shadow.lost_angle));
      if (dir == DIR_RIGHT) cmd = lost;
      else if (dir == DIR_MIDDLE) cmd = 0;
      else cmd = -lost;
    end
    if (cmd > 32767) cmd = 32767;
    if (cmd < -32768) cmd = -32768;
    return cmd[15:0];
  endfunction

  task automatic note_failure(input string msg);
    if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // input side: hold the item until taken, then maybe offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        steer_expect_q.push_back(steer_predict(in_ch.line_found, in_ch.line_position,
                                               in_ch.last_dir));
        n_accepted++;
      end
      if (frame_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_frame = frame_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.line_found    <= nxt_frame.found;
        in_ch.line_position <= nxt_frame.pos;
        in_ch.last_dir      <= nxt_frame.dir;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: check, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (steer_expect_q.size() == 0) begin
          note_failure($sformatf("unexpected steer_cmd %0d", out_ch.steer_cmd));
        end else begin
          if (out_ch.steer_cmd !== steer_expect_q[0])
            note_failure($sformatf("steer_cmd expected %0d got %0d",
                                   steer_expect_q[0], out_ch.steer_cmd));
          void'(steer_expect_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served  <= hold_asked;
        hold_left    <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input int val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   shadow.prop_gain   = val[15:0];
      REG_INTEG_GAIN:  shadow.integ_gain  = val[15:0];
      REG_DERIV_GAIN:  shadow.deriv_gain  = val[15:0];
      REG_ACCUM_GAIN:  shadow.accum_gain  = val[15:0];
      REG_ACCUM_MAX:   shadow.accum_max   = val[23:0];
      REG_ACCUM_MIN:   shadow.accum_min   = val[23:0];
      REG_LOST_ANGLE:  shadow.lost_angle  = val[15:0];
      REG_TERM_ENABLE: shadow.term_enable = val[2:0];
      default: ;
    endcase
  endtask

  function automatic int pick_gain();
    case ($urandom_range(5))
      0:       return -32768;
      1:       return 32767;
      2, 3:    return int'($urandom_range(1024)) - 512;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(5))
      0:       return -8388608;
      1:       return 8388607;
      2, 3:    return int'($urandom_range(131072)) - 65536;
      default: return int'($urandom_range(16777215)) - 8388608;
    endcase
  endfunction

  task automatic push_frame(input logic found, input int pos, input logic [1:0] dir);
    frame_t f;
    f.found = found;
    f.pos   = pos[6:0];
    f.dir   = dir;
    frame_q.push_back(f);
    n_queued++;
  endtask

  // sender pause: nothing left to send and every result back
  task automatic drain();
    while (!(n_accepted == n_queued && steer_expect_q.size() == 0)) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int cur_pos;
    int mode;
    in_ch.valid         = 1'b0;
    in_ch.line_found    = 1'b0;
    in_ch.line_position = '0;
    in_ch.last_dir      = '0;
    out_ch.ready        = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_n   = 1'b0;
    n_queued = 0;
    n_accepted = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asked = 0;
    hold_served = 0;
    idle_cycles = 0;
    shadow.prop_gain   = 16'sd256;
    shadow.integ_gain  = '0;
    shadow.deriv_gain  = '0;
    shadow.accum_gain  = 16'sd256;
    shadow.accum_max   = 24'h7fffff;
    shadow.accum_min   = 24'h800000;
    shadow.lost_angle  = '0;
    shadow.term_enable = 3'd5;
    integ_acc = 0;
    last_err  = 0;
    cur_pos   = CENTER_PIXEL;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: position extremes and every lost direction
    push_frame(1'b1, 64, DIR_MIDDLE);
    push_frame(1'b1, 0, DIR_LEFT);
    push_frame(1'b1, 127, DIR_RIGHT);
    push_frame(1'b1, 1, DIR_UNDEF);
    push_frame(1'b1, 126, DIR_LEFT);
    push_frame(1'b1, 63, DIR_RIGHT);
    push_frame(1'b1, 65, DIR_MIDDLE);
    push_frame(1'b0, 127, DIR_LEFT);
    push_frame(1'b0, 0, DIR_MIDDLE);
    push_frame(1'b0, 85, DIR_RIGHT);
    push_frame(1'b0, 42, DIR_UNDEF);
    drain();

    // all terms at full gain: saturation both ways, negated most-negative lost angle
    write_reg(REG_PROP_GAIN, 32767);
    write_reg(REG_INTEG_GAIN, -32768);
    write_reg(REG_DERIV_GAIN, 32767);
    write_reg(REG_ACCUM_GAIN, 32767);
    write_reg(REG_ACCUM_MAX, 8388607);
    write_reg(REG_ACCUM_MIN, -8388608);
    write_reg(REG_LOST_ANGLE, -32768);
    write_reg(REG_TERM_ENABLE, 7);
    push_frame(1'b1, 127, DIR_RIGHT);
    push_frame(1'b1, 127, DIR_RIGHT);
    push_frame(1'b1, 127, DIR_RIGHT);
    push_frame(1'b1, 0, DIR_LEFT);
    push_frame(1'b1, 0, DIR_LEFT);
    push_frame(1'b1, 64, DIR_MIDDLE);
    push_frame(1'b0, 64, DIR_LEFT);
    push_frame(1'b0, 64, DIR_MIDDLE);
    push_frame(1'b0, 64, DIR_RIGHT);
    push_frame(1'b0, 64, DIR_UNDEF);
    drain();

    // crossed integrator limits, integral term alone
    write_reg(REG_INTEG_GAIN, 256);
    write_reg(REG_ACCUM_GAIN, 256);
    write_reg(REG_ACCUM_MAX, -4096);
    write_reg(REG_ACCUM_MIN, 4096);
    write_reg(REG_TERM_ENABLE, 2);
    push_frame(1'b1, 127, DIR_RIGHT);
    push_frame(1'b1, 0, DIR_LEFT);
    push_frame(1'b1, 64, DIR_MIDDLE);
    push_frame(1'b1, 0, DIR_LEFT);
    drain();

    for (int p = 0; p < N_RAND_PHASES; p++) begin
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEG_GAIN, pick_gain());
      write_reg(REG_DERIV_GAIN, pick_gain());
      write_reg(REG_ACCUM_GAIN, pick_gain());
      write_reg(REG_ACCUM_MAX, pick_limit());
      write_reg(REG_ACCUM_MIN, pick_limit());
      write_reg(REG_LOST_ANGLE, pick_gain());
      write_reg(REG_TERM_ENABLE, p);
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 82 : (mode == 3) ? 28 : 0;
      recv_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 28 : 0;
      // long receiver hold-off while the sender keeps offering
      if (p == 0) hold_asked++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // half the time a tracked line drifting around, else a jump; sometimes a loss
        if ($urandom_range(1) == 1) begin
          cur_pos = cur_pos + int'($urandom_range(6)) - 3;
          if (cur_pos < 0) cur_pos = 0;
          if (cur_pos > 127) cur_pos = 127;
        end else begin
          cur_pos = $urandom_range(127);
        end
        push_frame($urandom_range(99) < 80, cur_pos, 2'($urandom_range(3)));
      end
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (steer_expect_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", steer_expect_q.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
